// ----- rtl/fden_pkg.sv -----
// package for the first decimal number extractor
// widths, character codes and the saturation value; no dependencies
package fden_pkg;

  localparam int unsigned CharW     = 8;
  localparam int unsigned MantW     = 60;
  localparam int unsigned CntW      = 5;
  localparam int unsigned MaxDigits = 18;
  localparam int unsigned DigitW    = 4;
  localparam int unsigned WideW     = MantW + DigitW;

  localparam logic [CharW-1:0] CharNul   = 8'h00;
  localparam logic [CharW-1:0] CharMinus = 8'h2D;
  localparam logic [CharW-1:0] CharPlus  = 8'h2B;
  localparam logic [CharW-1:0] CharPoint = 8'h2E;
  localparam logic [CharW-1:0] CharZero  = 8'h30;
  localparam logic [CharW-1:0] CharNine  = 8'h39;

  localparam logic [MantW-1:0] MantLimit = {MantW{1'b1}};

  // smaller of 10^MaxDigits - 1 and the mantissa limit
  function automatic logic [MantW-1:0] sat_value();
    logic [WideW-1:0] v;
    v = WideW'(1);
    for (int unsigned i = 0; i < MaxDigits && i < 19; i++) begin
      v = v * WideW'(10);
    end
    v = v - WideW'(1);
    if (v > {{DigitW{1'b0}}, MantLimit}) begin
      return MantLimit;
    end
    return v[MantW-1:0];
  endfunction

  localparam logic [MantW-1:0] SatValue = sat_value();

endpackage

// ----- rtl/fden_in_if.sv -----
// input channel: one string byte per transfer
// depends on fden_pkg
interface fden_in_if;
  logic                         valid;
  logic                         ready;
  logic [fden_pkg::CharW-1:0]   char_code;
  logic                         last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

// ----- rtl/fden_out_if.sv -----
// output channel: one parse result per string
// depends on fden_pkg
interface fden_out_if;
  logic                         valid;
  logic                         ready;
  logic                         found;
  logic                         negative;
  logic [fden_pkg::MantW-1:0]   mantissa;
  logic [fden_pkg::CntW-1:0]    frac_digits;
  logic                         overflow;

  modport source (output valid, output found, output negative, output mantissa,
                  output frac_digits, output overflow, input ready);
  modport sink   (input valid, input found, input negative, input mantissa,
                  input frac_digits, input overflow, output ready);
endinterface

// ----- rtl/first_decimal_number_extractor.sv -----
// first decimal number extractor: input register, scan state, result register
// a string's result is loaded into the result register when its last byte leaves the input register
// throughput: one byte per cycle, except while a last byte waits for out_o to take the
// previous result; the multiply-by-ten and add of the accumulator is combinational
// reset clears the input valid, the scan state and the result valid
// depends on fden_pkg, fden_in_if and fden_out_if
module first_decimal_number_extractor (
  input  logic        clk_i,
  input  logic        rst_ni,
  fden_in_if.sink     in_i,
  fden_out_if.source  out_o
);

  logic                            in_valid_q;
  logic [fden_pkg::CharW-1:0]      char_q;
  logic                            last_q;

  logic                            started_q, started_d;
  logic                            point_q, point_d;
  logic                            finished_q, finished_d;
  logic                            minus_q, minus_d;
  logic [fden_pkg::MantW-1:0]      accum_q, accum_d;
  logic [fden_pkg::CntW-1:0]       dcount_q, dcount_d;
  logic [fden_pkg::CntW-1:0]       fcount_q, fcount_d;
  logic                            too_many_q, too_many_d;

  logic                            out_valid_q;
  logic                            found_q, found_d;
  logic                            neg_q, neg_d;
  logic [fden_pkg::MantW-1:0]      mant_q, mant_d;
  logic [fden_pkg::CntW-1:0]       frac_q, frac_d;
  logic                            ovf_q, ovf_d;

  logic                            advance;
  logic                            proc;
  logic                            is_digit;
  logic [fden_pkg::DigitW-1:0]     digit;
  logic [fden_pkg::WideW-1:0]      ext;
  logic [fden_pkg::WideW-1:0]      next_acc;
  logic                            fits;
  logic                            take;

  assign advance    = !last_q || !out_valid_q || out_o.ready;
  assign proc       = in_valid_q && advance;
  assign in_i.ready = !in_valid_q || advance;

  assign is_digit = (char_q >= fden_pkg::CharZero) && (char_q <= fden_pkg::CharNine);
  assign digit    = fden_pkg::DigitW'(char_q - fden_pkg::CharZero);
  assign ext      = {{fden_pkg::DigitW{1'b0}}, accum_q};
  assign next_acc = (ext << 3) + (ext << 1) + {{(fden_pkg::WideW-fden_pkg::DigitW){1'b0}}, digit};
  assign fits     = (dcount_q < fden_pkg::CntW'(fden_pkg::MaxDigits)) &&
                    (next_acc <= {{fden_pkg::DigitW{1'b0}}, fden_pkg::MantLimit});

  always_comb begin
    started_d  = started_q;
    point_d    = point_q;
    finished_d = finished_q;
    minus_d    = minus_q;
    accum_d    = accum_q;
    dcount_d   = dcount_q;
    fcount_d   = fcount_q;
    too_many_d = too_many_q;
    take       = 1'b0;

    if (!finished_q) begin
      if (char_q == fden_pkg::CharNul) begin
        finished_d = 1'b1;
      end else if (!started_q) begin
        if (is_digit) begin
          started_d = 1'b1;
          take      = 1'b1;
        end else if (char_q == fden_pkg::CharMinus) begin
          started_d = 1'b1;
          minus_d   = 1'b1;
        end else if (char_q == fden_pkg::CharPlus) begin
          started_d = 1'b1;
        end
      end else if (is_digit) begin
        take = 1'b1;
      end else if (char_q == fden_pkg::CharPoint && !point_q) begin
        point_d = 1'b1;
      end else begin
        finished_d = 1'b1;
      end
    end

    if (take) begin
      if (fits) begin
        accum_d  = next_acc[fden_pkg::MantW-1:0];
        dcount_d = dcount_q + fden_pkg::CntW'(1);
        if (point_q) begin
          fcount_d = fcount_q + fden_pkg::CntW'(1);
        end
      end else begin
        too_many_d = 1'b1;
      end
    end

    // result from the updated scan state
    found_d = (dcount_d != '0) || too_many_d;
    neg_d   = found_d && minus_d;
    mant_d  = !found_d ? '0 : (too_many_d ? fden_pkg::SatValue : accum_d);
    frac_d  = found_d ? fcount_d : '0;
    ovf_d   = found_d && too_many_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      char_q <= in_i.char_code;
      last_q <= in_i.last_char;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q  <= 1'b0;
      point_q    <= 1'b0;
      finished_q <= 1'b0;
      minus_q    <= 1'b0;
      accum_q    <= '0;
      dcount_q   <= '0;
      fcount_q   <= '0;
      too_many_q <= 1'b0;
    end else if (proc) begin
      if (last_q) begin
        started_q  <= 1'b0;
        point_q    <= 1'b0;
        finished_q <= 1'b0;
        minus_q    <= 1'b0;
        accum_q    <= '0;
        dcount_q   <= '0;
        fcount_q   <= '0;
        too_many_q <= 1'b0;
      end else begin
        started_q  <= started_d;
        point_q    <= point_d;
        finished_q <= finished_d;
        minus_q    <= minus_d;
        accum_q    <= accum_d;
        dcount_q   <= dcount_d;
        fcount_q   <= fcount_d;
        too_many_q <= too_many_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proc && last_q) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc && last_q) begin
      found_q <= found_d;
      neg_q   <= neg_d;
      mant_q  <= mant_d;
      frac_q  <= frac_d;
      ovf_q   <= ovf_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.found       = found_q;
  assign out_o.negative    = neg_q;
  assign out_o.mantissa    = mant_q;
  assign out_o.frac_digits = frac_q;
  assign out_o.overflow    = ovf_q;

endmodule

// ----- verif/first_decimal_number_extractor_tb.sv -----
// testbench for first_decimal_number_extractor: streams strings byte by byte and
// checks each parse result against a scan predictor kept in the bench
// depends on fden_pkg, fden_in_if, fden_out_if and the extractor rtl
module first_decimal_number_extractor_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [fden_pkg::CharW-1:0] code;
    logic                       last;
  } text_byte_t;

  typedef struct packed {
    logic                       found;
    logic                       negative;
    logic [fden_pkg::MantW-1:0] mantissa;
    logic [fden_pkg::CntW-1:0]  frac_digits;
    logic                       overflow;
  } parse_result_t;

  localparam logic [63:0] MantCap  = (64'd1 << fden_pkg::MantW) - 64'd1;
  // ten to the eighteen minus one, below the 60-bit cap
  localparam logic [63:0] SatMant  = 64'd999_999_999_999_999_999;
  localparam int unsigned IdleLimit = 4000;
  localparam int unsigned HoldCycles = 300;

  logic clk_i = 1'b0;
  logic rst_ni;

  fden_in_if  in_if ();
  fden_out_if out_if ();

  first_decimal_number_extractor DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  text_byte_t    text_q[$];
  parse_result_t parse_results_q[$];
  int unsigned   bytes_pushed;
  int unsigned   bytes_taken;
  int unsigned   mismatches;
  int unsigned   idle_cycles;
  int unsigned   send_idle_pct;
  int unsigned   stall_pct;
  int unsigned   hold_left;
  logic          long_hold_req;
  logic          in_fire;
  logic          out_fire;
  parse_result_t want;

  // scan state of the predictor
  logic                      scan_started;
  logic                      scan_point;
  logic                      scan_done;
  logic                      scan_minus;
  logic [63:0]               scan_accum;
  logic [fden_pkg::CntW-1:0] scan_digits;
  logic [fden_pkg::CntW-1:0] scan_frac;
  logic                      scan_overflow;

  task automatic scan_clear();
    scan_started  = 1'b0;
    scan_point    = 1'b0;
    scan_done     = 1'b0;
    scan_minus    = 1'b0;
    scan_accum    = '0;
    scan_digits   = '0;
    scan_frac     = '0;
    scan_overflow = 1'b0;
  endtask

  task automatic add_digit(input logic [63:0] d);
    if (scan_digits < fden_pkg::MaxDigits && scan_accum <= (MantCap - d) / 64'd10) begin
      scan_accum  = scan_accum * 64'd10 + d;
      scan_digits = scan_digits + 1'b1;
      if (scan_point) begin
        scan_frac = scan_frac + 1'b1;
      end
    end else begin
      scan_overflow = 1'b1;
    end
  endtask

  task automatic scan_byte(input logic [fden_pkg::CharW-1:0] ch, input logic last);
    logic          is_digit;
    parse_result_t res;
    is_digit = (ch >= fden_pkg::CharZero) && (ch <= fden_pkg::CharNine);
    if (!scan_done) begin
      if (ch == fden_pkg::CharNul) begin
        scan_done = 1'b1;
      end else if (!scan_started) begin
        if (is_digit) begin
          scan_started = 1'b1;
          add_digit(64'(ch - fden_pkg::CharZero));
        end else if (ch == fden_pkg::CharMinus) begin
          scan_started = 1'b1;
          scan_minus   = 1'b1;
        end else if (ch == fden_pkg::CharPlus) begin
          scan_started = 1'b1;
        end
      end else if (is_digit) begin
        add_digit(64'(ch - fden_pkg::CharZero));
      end else if (ch == fden_pkg::CharPoint && !scan_point) begin
        scan_point = 1'b1;
      end else begin
        scan_done = 1'b1;
      end
    end
    if (last) begin
      res = '0;
      if (scan_digits != '0 || scan_overflow) begin
        res.found       = 1'b1;
        res.negative    = scan_minus;
        res.mantissa    = scan_overflow ? SatMant[fden_pkg::MantW-1:0]
                                        : scan_accum[fden_pkg::MantW-1:0];
        res.frac_digits = scan_frac;
        res.overflow    = scan_overflow;
      end
      parse_results_q.push_back(res);
      scan_clear();
    end
  endtask

  task automatic check_field(input string field, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, exp_v, act_v);
    end
  endtask

  // pushes one string, marking its final byte
  task automatic push_text(input logic [fden_pkg::CharW-1:0] txt[$]);
    text_byte_t item;
    foreach (txt[i]) begin
      item.code = txt[i];
      item.last = (i == txt.size() - 1);
      text_q.push_back(item);
      bytes_pushed++;
    end
  endtask

  task automatic push_str(input string s);
    logic [fden_pkg::CharW-1:0] txt[$];
    for (int i = 0; i < s.len(); i++) begin
      txt.push_back(s[i]);
    end
    push_text(txt);
  endtask

  task automatic push_byte(input logic [fden_pkg::CharW-1:0] code, input logic last);
    text_byte_t item;
    item.code = code;
    item.last = last;
    text_q.push_back(item);
    bytes_pushed++;
  endtask

  task automatic gen_string();
    logic [fden_pkg::CharW-1:0] txt[$];
    logic [fden_pkg::CharW-1:0] c;
    int unsigned                n;
    if ($urandom_range(99) < 15) begin
      n = $urandom_range(8, 1);
      repeat (n) txt.push_back(fden_pkg::CharW'($urandom_range(255)));
    end else begin
      n = $urandom_range(2);
      repeat (n) begin
        do begin
          c = fden_pkg::CharW'($urandom_range(255, 1));
        end while ((c >= fden_pkg::CharZero && c <= fden_pkg::CharNine) ||
                   c == fden_pkg::CharMinus || c == fden_pkg::CharPlus);
        txt.push_back(c);
      end
      case ($urandom_range(2))
        1: txt.push_back(fden_pkg::CharMinus);
        2: txt.push_back(fden_pkg::CharPlus);
        default: ;
      endcase
      n = ($urandom_range(7) == 0) ? $urandom_range(22, 15) : $urandom_range(5);
      repeat (n) txt.push_back(fden_pkg::CharZero + fden_pkg::CharW'($urandom_range(9)));
      if ($urandom_range(1)) begin
        txt.push_back(fden_pkg::CharPoint);
        n = ($urandom_range(9) == 0) ? $urandom_range(20, 10) : $urandom_range(5);
        repeat (n) txt.push_back(fden_pkg::CharZero + fden_pkg::CharW'($urandom_range(9)));
      end
      if ($urandom_range(1)) begin
        n = $urandom_range(3, 1);
        repeat (n) txt.push_back(fden_pkg::CharW'($urandom_range(255)));
      end
      if (txt.size() == 0) begin
        txt.push_back(fden_pkg::CharW'($urandom_range(255)));
      end
    end
    push_text(txt);
  endtask

  task automatic drain();
    while (bytes_taken != bytes_pushed || parse_results_q.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  task automatic run_phase(input int unsigned idle_pct, input int unsigned stall,
                           input int unsigned n_bytes);
    int unsigned goal;
    send_idle_pct = idle_pct;
    stall_pct     = stall;
    goal          = bytes_pushed + n_bytes;
    while (bytes_pushed < goal) gen_string();
    drain();
  endtask

  // sender
  always @(negedge clk_i) begin
    text_byte_t item;
    if (rst_ni && (!in_if.valid || in_fire)) begin
      if (text_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        item = text_q.pop_front();
        in_if.valid     <= 1'b1;
        in_if.char_code <= item.code;
        in_if.last_char <= item.last;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk_i) begin
    if (long_hold_req) begin
      hold_left     = HoldCycles;
      long_hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // transfer monitor, result check and watchdog
  always @(posedge clk_i) begin
    in_fire  = rst_ni && in_if.valid && in_if.ready;
    out_fire = rst_ni && out_if.valid && out_if.ready;
    if (in_fire) begin
      scan_byte(in_if.char_code, in_if.last_char);
      bytes_taken++;
    end
    if (out_fire) begin
      if (parse_results_q.size() == 0) begin
        mismatches++;
        $display("%0t ns: result transfer with none expected, got found %0b mantissa %0d",
                 $time, out_if.found, out_if.mantissa);
      end else begin
        want = parse_results_q.pop_front();
        check_field("found", 64'(want.found), 64'(out_if.found));
        check_field("negative", 64'(want.negative), 64'(out_if.negative));
        check_field("mantissa", 64'(want.mantissa), 64'(out_if.mantissa));
        check_field("frac_digits", 64'(want.frac_digits), 64'(out_if.frac_digits));
        check_field("overflow", 64'(want.overflow), 64'(out_if.overflow));
      end
    end
    if (!rst_ni || in_fire || out_fire) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("first_decimal_number_extractor verification failed");
        $finish;
      end
    end
  end

  initial begin
    in_if.valid     = 1'b0;
    in_if.char_code = '0;
    in_if.last_char = 1'b0;
    out_if.ready    = 1'b0;
    rst_ni          = 1'b0;
    in_fire         = 1'b0;
    out_fire        = 1'b0;
    long_hold_req   = 1'b0;
    hold_left       = 0;
    idle_cycles     = 0;
    bytes_pushed    = 0;
    bytes_taken     = 0;
    mismatches      = 0;
    send_idle_pct   = 0;
    stall_pct       = 0;
    scan_clear();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // minus zero, lone sign, sign and point, second point ends the number
    push_str("-0");
    push_str("+");
    push_str("-.");
    push_str("1.2.");
    // zero byte as last, zero byte before a digit, high byte before a digit
    push_byte("7", 1'b0);
    push_byte(fden_pkg::CharNul, 1'b1);
    push_byte(fden_pkg::CharNul, 1'b0);
    push_byte("5", 1'b1);
    push_byte(8'hFF, 1'b0);
    push_byte(fden_pkg::CharNine, 1'b1);
    push_str("a+0.05!");
    push_str("9");
    drain();

    run_phase(0, 0, 280);
    run_phase(60, 0, 280);
    run_phase(0, 60, 280);
    run_phase(7, 7, 280);

    // receiver blocked for a long stretch while bytes keep coming
    send_idle_pct = 0;
    stall_pct     = 0;
    long_hold_req = 1'b1;
    repeat (40) push_str("-12");
    drain();

    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("first_decimal_number_extractor verification clean");
    end else begin
      $display("first_decimal_number_extractor verification failed");
    end
    $finish;
  end

endmodule
